>>> rtl/o2bs_pkg.sv
`timescale 1ns / 1ps
package o2bs_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned InDataW = 136;
	localparam int unsigned OutDataW = 40;
	localparam logic [3:0] PcReg = 4'hF;
	localparam logic [WordW-1:0] PcOffset = 32'd8;
	localparam logic [WordW-1:0] PcAlignMask = ~32'd3;
	localparam logic [7:0] FullWordShift = 8'd32;

	typedef enum logic [1:0] {
		SH_LSL,
		SH_LSR,
		SH_ASR,
		SH_ROR
	} shift_kind_t;

	typedef enum logic [1:0] {
		MK_ALL,
		MK_LEFT,
		MK_RIGHT,
		MK_NONE
	} mask_kind_t;

	typedef enum logic [1:0] {
		CS_FIXED,
		CS_ROT31,
		CS_ROT0
	} carry_sel_t;

	typedef struct packed {
		logic [WordW-1:0] x;
		logic [4:0] rot;
		logic [4:0] amt;
		mask_kind_t mk;
		carry_sel_t cs;
		logic cfix;
		logic fill;
	} dec_t;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic [2:0] rot;
		logic [WordW-1:0] mask;
		carry_sel_t cs;
		logic cfix;
		logic fill;
	} mid_t;

endpackage

>>> rtl/operand2_barrel_shifter.sv
`timescale 1ns / 1ps
// channel  dir  bits  contents
// s_*      in   136   instruction, rm_value, rs_value, program_counter, carry_in
// m_*      out  40    operand_value, carry_out
//
// three register stages: decode and pc fixup, byte rotate with mask build,
// bit rotate with fill and carry select
// one transfer per cycle sustained while m_tready stays high
// arst_n clears the stage valid bits only
// each stage holds while the next one is full and stalled; bubbles close up
module operand2_barrel_shifter (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// instruction[31:0], rm_value[63:32], rs_value[95:64], program_counter[127:96],
	// carry_in[128], zero[135:129]
	input  logic [o2bs_pkg::InDataW-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// operand_value[31:0], carry_out[32], zero[39:33]
	output logic [o2bs_pkg::OutDataW-1:0] m_tdata
);

	logic dec_valid;
	logic dec_ready;
	o2bs_pkg::dec_t dec_data;
	logic mid_valid;
	logic mid_ready;
	o2bs_pkg::mid_t mid_data;
	logic [31:0] operand_value;
	logic carry_out;

	o2bs_decode u_decode (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.instruction     (s_tdata[31:0]),
		.rm_value        (s_tdata[63:32]),
		.rs_value        (s_tdata[95:64]),
		.program_counter (s_tdata[127:96]),
		.carry_in        (s_tdata[128]),
		.out_valid       (dec_valid),
		.out_ready       (dec_ready),
		.out_data        (dec_data)
	);

	o2bs_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (dec_valid),
		.in_ready  (dec_ready),
		.in_data   (dec_data),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	o2bs_finish u_finish (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (mid_valid),
		.in_ready      (mid_ready),
		.in_data       (mid_data),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.operand_value (operand_value),
		.carry_out     (carry_out)
	);

	assign m_tdata = {7'd0, carry_out, operand_value};

`ifndef SYNTHESIS
	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!dec_valid |-> s_tready)
		else $error("empty decode stage refuses input");
	a_out_from_mid: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(mid_valid))
		else $error("output valid without a middle-stage item");
`endif

endmodule

>>> rtl/o2bs_decode.sv
`timescale 1ns / 1ps
module o2bs_decode (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [31:0] instruction,
	input  logic [31:0] rm_value,
	input  logic [31:0] rs_value,
	input  logic [31:0] program_counter,
	input  logic carry_in,
	output logic out_valid,
	input  logic out_ready,
	output o2bs_pkg::dec_t out_data
);

	logic valid_s1;
	o2bs_pkg::dec_t dec_s1;
	o2bs_pkg::dec_t d;
	logic [31:0] pc8;
	logic [31:0] x;
	logic [31:0] rs;
	logic [7:0] a;
	logic pass;
	logic rrx;
	o2bs_pkg::shift_kind_t kind;

	always_comb begin
		pc8 = (program_counter + o2bs_pkg::PcOffset) & o2bs_pkg::PcAlignMask;
		x = (instruction[3:0] == o2bs_pkg::PcReg) ? pc8 : rm_value;
		rs = (instruction[11:8] == o2bs_pkg::PcReg) ? pc8 : rs_value;
		kind = o2bs_pkg::shift_kind_t'(instruction[6:5]);
		a = 8'd0;
		pass = 1'b0;
		rrx = 1'b0;
		d.x = x;
		d.rot = 5'd0;
		d.amt = 5'd0;
		d.mk = o2bs_pkg::MK_ALL;
		d.cs = o2bs_pkg::CS_FIXED;
		d.cfix = carry_in;
		d.fill = 1'b0;
		if (instruction[25]) begin
			d.x = {24'd0, instruction[7:0]};
			d.rot = {instruction[11:8], 1'b0};
			if (instruction[11:8] != 4'd0) begin
				d.cs = o2bs_pkg::CS_ROT31;
			end
		end else begin
			if (instruction[4]) begin
				a = rs[7:0];
				pass = (a == 8'd0);
			end else begin
				a = {3'd0, instruction[11:7]};
				if (instruction[11:7] == 5'd0) begin
					unique case (kind)
						o2bs_pkg::SH_LSL: pass = 1'b1;
						o2bs_pkg::SH_ROR: rrx = 1'b1;
						o2bs_pkg::SH_LSR,
						o2bs_pkg::SH_ASR: a = o2bs_pkg::FullWordShift;
					endcase
				end
			end
			if (pass) begin
				d.cfix = carry_in;
			end else if (rrx) begin
				// rotate by one, top bit replaced by incoming carry
				d.rot = 5'd1;
				d.amt = 5'd1;
				d.mk = o2bs_pkg::MK_RIGHT;
				d.cfix = x[0];
				d.fill = carry_in;
			end else begin
				unique case (kind)
					o2bs_pkg::SH_LSL: begin
						if (a[7:5] == 3'd0) begin
							d.rot = 5'd0 - a[4:0];
							d.amt = a[4:0];
							d.mk = o2bs_pkg::MK_LEFT;
							d.cs = o2bs_pkg::CS_ROT0;
						end else begin
							d.mk = o2bs_pkg::MK_NONE;
							d.cfix = (a == o2bs_pkg::FullWordShift) ? x[0] : 1'b0;
						end
					end
					o2bs_pkg::SH_LSR: begin
						if (a[7:5] == 3'd0) begin
							d.rot = a[4:0];
							d.amt = a[4:0];
							d.mk = o2bs_pkg::MK_RIGHT;
							d.cs = o2bs_pkg::CS_ROT31;
						end else begin
							d.mk = o2bs_pkg::MK_NONE;
							d.cfix = (a == o2bs_pkg::FullWordShift) ? x[31] : 1'b0;
						end
					end
					o2bs_pkg::SH_ASR: begin
						d.fill = x[31];
						if (a[7:5] == 3'd0) begin
							d.rot = a[4:0];
							d.amt = a[4:0];
							d.mk = o2bs_pkg::MK_RIGHT;
							d.cs = o2bs_pkg::CS_ROT31;
						end else begin
							d.mk = o2bs_pkg::MK_NONE;
							d.cfix = x[31];
						end
					end
					o2bs_pkg::SH_ROR: begin
						if (a[4:0] == 5'd0) begin
							d.cfix = x[31];
						end else begin
							d.rot = a[4:0];
							d.cs = o2bs_pkg::CS_ROT31;
						end
					end
				endcase
			end
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dec_s1 <= d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data = dec_s1;

`ifndef SYNTHESIS
	// a full-width pass never picks its carry from the low bit
	a_no_rot0_on_pass: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(dec_s1.mk == o2bs_pkg::MK_ALL && dec_s1.cs == o2bs_pkg::CS_ROT0))
		else $error("left-shift carry select without left mask");
	// zero or sign results never come from a rotated bit
	a_none_fixed_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && dec_s1.mk == o2bs_pkg::MK_NONE) |-> dec_s1.cs == o2bs_pkg::CS_FIXED)
		else $error("full-width shift with rotated carry select");
`endif

endmodule

>>> rtl/o2bs_rotate.sv
`timescale 1ns / 1ps
module o2bs_rotate (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  o2bs_pkg::dec_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output o2bs_pkg::mid_t out_data
);

	logic valid_s2;
	o2bs_pkg::mid_t mid_s2;
	o2bs_pkg::mid_t m;
	logic [31:0] ones;

	always_comb begin
		ones = {32{1'b1}};
		// coarse rotate right by whole bytes
		case (in_data.rot[4:3])
			2'd1:    m.word = {in_data.x[7:0], in_data.x[31:8]};
			2'd2:    m.word = {in_data.x[15:0], in_data.x[31:16]};
			2'd3:    m.word = {in_data.x[23:0], in_data.x[31:24]};
			default: m.word = in_data.x;
		endcase
		unique case (in_data.mk)
			o2bs_pkg::MK_ALL:   m.mask = ones;
			o2bs_pkg::MK_LEFT:  m.mask = ones << in_data.amt;
			o2bs_pkg::MK_RIGHT: m.mask = ones >> in_data.amt;
			o2bs_pkg::MK_NONE:  m.mask = 32'd0;
		endcase
		m.rot = in_data.rot[2:0];
		m.cs = in_data.cs;
		m.cfix = in_data.cfix;
		m.fill = in_data.fill;
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mid_s2 <= m;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = mid_s2;

endmodule

>>> rtl/o2bs_finish.sv
`timescale 1ns / 1ps
module o2bs_finish (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  o2bs_pkg::mid_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output logic [31:0] operand_value,
	output logic carry_out
);

	logic valid_s3;
	logic [31:0] value_s3;
	logic carry_s3;
	logic [31:0] w;
	logic [31:0] v;
	logic c;

	always_comb begin
		// fine rotate right by 0..7
		w = (in_data.word >> in_data.rot)
			| (in_data.word << (6'd32 - {3'd0, in_data.rot}));
		v = (w & in_data.mask) | (~in_data.mask & {32{in_data.fill}});
		case (in_data.cs)
			o2bs_pkg::CS_ROT31: c = w[31];
			o2bs_pkg::CS_ROT0:  c = w[0];
			default:            c = in_data.cfix;
		endcase
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_s3 <= v;
			carry_s3 <= c;
		end
	end

	assign out_valid = valid_s3;
	assign operand_value = value_s3;
	assign carry_out = carry_s3;

`ifndef SYNTHESIS
	// an all-clear mask leaves only zero or the fill everywhere
	a_none_is_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_data.mask == 32'd0)
		|=> (value_s3 == 32'd0 || value_s3 == {32{1'b1}}))
		else $error("full-width shift result not flat");
`endif

endmodule
